/* rtl/core/alm_pkg.sv */
// Package for the audio level meter with peak hold.
// Holds widths, level constants, the controller state type and control structs.
package alm_pkg;

    localparam int MaxPeriodFrames = 4096;
    localparam int FcW = $clog2(MaxPeriodFrames + 1);
    localparam int SumW = 44;
    localparam int LvlW = 17;

    localparam logic signed [LvlW-1:0] LevelFloor = -17'sd46080;
    localparam logic signed [LvlW-1:0] HoldMin = -17'sd46336;
    localparam logic signed [LvlW-1:0] HoldReset = -17'sd30720;
    localparam logic [31:0] DbPerOctaveQ16 = 32'd50504054;

    localparam logic [0:0] RegChannelCount = 1'b0;
    localparam logic [0:0] RegHoldDecay = 1'b1;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_LOAD,
        ST_NORM,
        ST_SQ,
        ST_SQ2,
        ST_NEXT,
        ST_MUL,
        ST_SCALE,
        ST_HOLD,
        ST_OUT
    } alm_state_t;

    typedef struct packed {
        logic accept;
        logic load_op;
        logic [1:0] op_sel;
        logic norm_step;
        logic sq_step;
        logic sq_fix;
        logic mul_step;
        logic scale_step;
        logic hold_step;
        logic clear;
    } alm_cmd_t;

    typedef struct packed {
        logic period_done;
        logic norm_done;
        logic frac_done;
        logic [1:0] op_idx;
    } alm_stat_t;

endpackage

/* rtl/core/alm_if.sv */
// Valid/ready channel interfaces for the level meter.
// Widths are written as literals here; alm_pkg is not used.
interface alm_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic period_end;
    modport source (output valid, left_sample, right_sample, period_end, input ready);
    modport sink (input valid, left_sample, right_sample, period_end, output ready);
endinterface

interface alm_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] rms_level;
    logic signed [16:0] peak_level;
    logic signed [16:0] held_peak;
    modport source (output valid, rms_level, peak_level, held_peak, input ready);
    modport sink (input valid, rms_level, peak_level, held_peak, output ready);
endinterface

interface alm_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/alm_ctrl.sv */
// Controller state machine for the level meter.
// Sequences accumulation, the log2 iterations and the result transfer; uses alm_pkg.
module alm_ctrl
    import alm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  alm_stat_t stat,
    output alm_cmd_t cmd
);

    alm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.op_sel = stat.op_idx;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.period_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Operands: square sum, frame count, peak squared.
                cmd.load_op = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (stat.norm_done)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.sq_fix = 1'b1;
                state_next = stat.frac_done ? ST_NEXT : ST_SQ;
            end
            ST_NEXT:
            begin
                if (stat.op_idx == 2'd2)
                    state_next = ST_MUL;
                else
                begin
                    cmd.load_op = 1'b1;
                    cmd.op_sel = stat.op_idx + 2'd1;
                    state_next = ST_NORM;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_step = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                cmd.hold_step = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

endmodule

/* rtl/core/alm_dp.sv */
// Datapath of the level meter: accumulators, log2 unit and hold update.
// Driven by alm_ctrl commands; uses alm_pkg.
module alm_dp
    import alm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  alm_cmd_t cmd,
    output alm_stat_t stat,
    input  logic [1:0] channel_count,
    input  logic [11:0] hold_decay_step,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic period_end,
    output logic signed [LvlW-1:0] rms_level,
    output logic signed [LvlW-1:0] peak_level,
    output logic signed [LvlW-1:0] held_peak
);

    logic [15:0] peak_reg;
    logic [SumW-1:0] sum_reg;
    logic [FcW-1:0] fc_reg;
    logic signed [LvlW-1:0] hold_reg, hold_next;
    logic [1:0] op_reg;
    logic [SumW-1:0] x_reg;          // operand being normalized
    logic [5:0] e_reg;
    logic [31:0] m_reg;              // Q30 mantissa, below 2^31
    logic [63:0] sq_reg;
    logic [3:0] bit_reg;
    logic [15:0] frac_reg;
    logic zero_reg;
    logic signed [23:0] lp_reg;      // accumulated log in Q16
    logic [55:0] prod_reg;
    logic neg_reg;
    logic signed [LvlW-1:0] rms_reg, pk_reg;

    // Mono sample and magnitude.
    logic signed [16:0] mix;
    logic signed [16:0] s;
    logic [15:0] a;
    logic [31:0] a_sq;
    logic [FcW-1:0] fc_inc;
    assign mix = 17'(left_sample) + 17'(right_sample);
    always_comb
    begin
        if (channel_count[1])
            s = (mix + $signed({16'd0, mix[16]})) >>> 1;
        else
            s = 17'(left_sample);
        a = s[16] ? 16'(-s) : 16'(s);
    end
    assign a_sq = a * a;
    assign fc_inc = fc_reg + 1'b1;
    assign stat.period_done = period_end || (fc_inc == FcW'(MaxPeriodFrames));
    assign stat.op_idx = op_reg;
    assign stat.norm_done = x_reg[SumW-1] || (e_reg == 6'd0);
    assign stat.frac_done = (bit_reg == 4'd0);

    logic [SumW-1:0] op_val;
    always_comb
    begin
        case (cmd.op_sel)
            2'd0: op_val = sum_reg;
            2'd1: op_val = SumW'(fc_reg);
            default: op_val = SumW'({16'd0, peak_reg} * {16'd0, peak_reg});
        endcase
    end

    // Square of mantissa, truncated back to Q30, then renormalized.
    logic [31:0] m_sq;
    assign m_sq = sq_reg[61:30];

    logic signed [23:0] log_val;
    assign log_val = {2'b00, e_reg, frac_reg};

    logic [31:0] lp_mag;
    assign lp_mag = lp_reg[23] ? 32'(-lp_reg) : 32'(lp_reg);
    logic [24:0] r_round;
    assign r_round = 25'((prod_reg + 56'h80000000) >> 32);
    logic signed [LvlW-1:0] lvl;
    always_comb
    begin
        if (zero_reg)
            lvl = LevelFloor;
        else if (neg_reg)
            lvl = (r_round > 25'd46080) ? LevelFloor : -LvlW'(r_round);
        else
            lvl = '0;
    end

    logic signed [LvlW:0] hdec;
    assign hdec = 18'(hold_reg) - 18'({6'd0, hold_decay_step});
    always_comb
    begin
        if (pk_reg > hold_reg)
            hold_next = pk_reg;
        else if (hdec < 18'(HoldMin))
            hold_next = HoldMin;
        else
            hold_next = LvlW'(hdec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            sum_reg <= '0;
            fc_reg <= '0;
            hold_reg <= HoldReset;
            op_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (a > peak_reg)
                    peak_reg <= a;
                sum_reg <= sum_reg + SumW'(a_sq);
                fc_reg <= fc_inc;
            end
            if (cmd.load_op)
                op_reg <= cmd.op_sel;
            if (cmd.hold_step)
                hold_reg <= hold_next;
            if (cmd.clear)
            begin
                peak_reg <= '0;
                sum_reg <= '0;
                fc_reg <= '0;
                op_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            x_reg <= op_val;
            e_reg <= 6'(SumW - 1);
            bit_reg <= 4'd15;
            frac_reg <= '0;
            if (cmd.op_sel == 2'd0)
                lp_reg <= -24'sd1966080;
            if (cmd.op_sel == 2'd0 || cmd.op_sel == 2'd2)
                zero_reg <= (op_val == '0);
        end
        if (cmd.norm_step)
        begin
            if (!stat.norm_done)
            begin
                x_reg <= x_reg << 1;
                e_reg <= e_reg - 1'b1;
            end
            else
                m_reg <= {1'b0, x_reg[SumW-1:SumW-31]};
        end
        if (cmd.sq_step)
            sq_reg <= {32'd0, m_reg} * {32'd0, m_reg};
        if (cmd.sq_fix)
        begin
            if (m_sq[31])
            begin
                m_reg <= m_sq >> 1;
                frac_reg[bit_reg] <= 1'b1;
            end
            else
                m_reg <= m_sq;
            bit_reg <= bit_reg - 1'b1;
        end
        if (cmd.sq_fix && stat.frac_done)
        begin
            // Square sum adds, frame count subtracts; peak log replaces lp_reg.
            case (op_reg)
                2'd0: lp_reg <= lp_reg + {2'b00, e_reg, frac_reg[15:1],
                                          m_sq[31] | frac_reg[0]};
                2'd1: lp_reg <= lp_reg - {2'b00, e_reg, frac_reg[15:1],
                                          m_sq[31] | frac_reg[0]};
                default: lp_reg <= {2'b00, e_reg, frac_reg[15:1], m_sq[31] | frac_reg[0]}
                                   - 24'sd1966080;
            endcase
        end
        if (cmd.mul_step)
        begin
            // The peak log is scaled here; the rms log is scaled alongside it below.
            prod_reg <= 56'(lp_mag) * 56'(DbPerOctaveQ16);
            neg_reg <= lp_reg[23];
        end
        if (cmd.scale_step)
            pk_reg <= lvl;
    end

    // The rms log is captured before the peak operand overwrites lp_reg.
    logic signed [23:0] lp_rms_reg;
    logic zero_rms_reg;
    logic [55:0] prod_rms;
    always_ff @(posedge clk)
    begin
        if (cmd.load_op && cmd.op_sel == 2'd2)
        begin
            lp_rms_reg <= lp_reg;
            zero_rms_reg <= zero_reg;
        end
        if (cmd.mul_step)
            prod_rms <= 56'(lp_rms_reg[23] ? 32'(-lp_rms_reg) : 32'(lp_rms_reg))
                        * 56'(DbPerOctaveQ16);
        if (cmd.scale_step)
        begin
            if (zero_rms_reg)
                rms_reg <= LevelFloor;
            else if (lp_rms_reg[23])
                rms_reg <= (25'((prod_rms + 56'h80000000) >> 32) > 25'd46080) ? LevelFloor
                           : -LvlW'(25'((prod_rms + 56'h80000000) >> 32));
            else
                rms_reg <= '0;
        end
    end

    assign rms_level = rms_reg;
    assign peak_level = pk_reg;
    assign held_peak = hold_reg;

endmodule

/* rtl/core/alm_cfg.sv */
// Configuration registers of the level meter.
// Uses alm_pkg register indexes.
module alm_cfg
    import alm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    alm_cfg_if.sink cfg,
    output logic [1:0] channel_count,
    output logic [11:0] hold_decay_step
);

    logic [1:0] cc_reg;
    logic [11:0] step_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= 2'd1;
            step_reg <= 12'd77;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == RegChannelCount)
                cc_reg <= cfg.data[1:0];
            else
                step_reg <= cfg.data;
        end
    end
    assign channel_count = cc_reg;
    assign hold_decay_step = step_reg;

endmodule

/* rtl/core/audio_level_meter_peak_hold.sv */
// Audio level meter with peak hold: one frame transfer per cycle while accumulating.
// The period-ending transfer starts a log2 pass over square sum, frame count and peak
// squared; each operand is normalized, then squared and renormalized once per fraction
// bit, and the result is valid after the multiply, scale and hold-update steps that
// follow the third operand. Input is held off until the result is taken.
// Reset (rst_n, asynchronous) clears the accumulators and sets the hold to -120 dB.
module audio_level_meter_peak_hold
    import alm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    alm_in_if.sink in_ch,
    alm_out_if.source out_ch,
    alm_cfg_if.sink cfg
);

    alm_cmd_t cmd;
    alm_stat_t stat;
    logic [1:0] channel_count;
    logic [11:0] hold_decay_step;

    alm_cfg u_cfg (.clk, .rst_n, .cfg, .channel_count, .hold_decay_step);

    alm_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat, .cmd
    );

    alm_dp u_dp (
        .clk, .rst_n, .cmd, .stat, .channel_count, .hold_decay_step,
        .left_sample(in_ch.left_sample), .right_sample(in_ch.right_sample),
        .period_end(in_ch.period_end),
        .rms_level(out_ch.rms_level), .peak_level(out_ch.peak_level),
        .held_peak(out_ch.held_peak)
    );

endmodule

/* rtl/core/alm_checker.sv */
// Port-level checker for the level meter, bound to the top level.
// Sees only the top-level channel ports.
module alm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic signed [16:0] held_peak,
    input logic signed [16:0] peak_level
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_level <= 17'sd0 && held_peak >= -17'sd46336))
        else $error("level out of range");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(held_peak))
        else $error("result dropped");
endmodule

bind audio_level_meter_peak_hold alm_checker u_chk (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .held_peak(out_ch.held_peak), .peak_level(out_ch.peak_level)
);
